### rtl/core/heap_allocator_with_access_check_top_macros.svh
// assertion macros for the heap allocator top level
`ifndef HEAP_ALLOCATOR_WITH_ACCESS_CHECK_TOP_MACROS_SVH
`define HEAP_ALLOCATOR_WITH_ACCESS_CHECK_TOP_MACROS_SVH

// same-cycle implication
`define HAC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hac assertion failed");

// next-cycle implication
`define HAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hac assertion failed");

`endif

### rtl/core/hac_pkg.sv
// shared constants for the heap allocator with access check
`default_nettype none
package hac_pkg;
  localparam int MemBytesDef  = 65536;
  localparam int HeapBytesDef = 4096;

  localparam logic [1:0] KindLoad  = 2'd0;
  localparam logic [1:0] KindStore = 2'd1;
  localparam logic [1:0] KindAlloc = 2'd2;
  localparam logic [1:0] KindFree  = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StDenied  = 2'd1;
  localparam logic [1:0] StBadFree = 2'd2;
  localparam logic [1:0] StNoSpace = 2'd3;

  localparam logic [1:0] MapFree = 2'd0;
  localparam logic [1:0] MapHead = 2'd1;
  localparam logic [1:0] MapCont = 2'd2;

  localparam logic [1:0] CfgCodeStart = 2'd0;
  localparam logic [1:0] CfgCodeEnd   = 2'd1;
  localparam logic [1:0] CfgHeapStart = 2'd2;
  localparam logic [1:0] CfgFitMode   = 2'd3;

  localparam logic [15:0] CodeStartRst = 16'd4;
  localparam logic [15:0] CodeEndRst   = 16'd16384;
  localparam logic [15:0] HeapStartRst = 16'd32768;
endpackage
`default_nettype wire

### rtl/core/hac_ram.sv
// single-port-write, single-port-read synchronous ram with registered read
`default_nettype none
module hac_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/heap_allocator_with_access_check_top.sv
// heap allocator with byte map, access-checked loads and stores
// after reset a pass over max(MEM_BYTES, HEAP_BYTES) addresses zeroes both memories
// load/store: range check, map read and check per heap byte, data read or write per byte
// alloc: a map read and check per byte scanned, then a map write per byte marked
// free: a map clear and read per cleared byte; the map port gives one read per cycle
// one item at a time; a new item is taken while the previous result beat still waits
`default_nettype none
`include "heap_allocator_with_access_check_top_macros.svh"
module heap_allocator_with_access_check_top #(
  parameter int MEM_BYTES  = hac_pkg::MemBytesDef,
  parameter int HEAP_BYTES = hac_pkg::HeapBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] address_i,
  input  wire logic [12:0] byte_count_i,
  input  wire logic [31:0] write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      result_value_o,
  output logic [1:0]       status_o
);
  localparam int AW   = $clog2(MEM_BYTES);
  localparam int HW   = $clog2(HEAP_BYTES);
  localparam int OW   = HW + 1;
  localparam int KW   = (OW > 13) ? OW : 13;
  localparam int RW   = ((HW > 16) ? HW : 16) + 2;
  localparam int ClrN = (MEM_BYTES > HEAP_BYTES) ? MEM_BYTES : HEAP_BYTES;
  localparam int CW   = $clog2(ClrN);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CHK, S_MRD, S_MCHK, S_DRD, S_DCHK, S_DWR,
    S_AINIT, S_ACAND, S_ARD, S_ACHK, S_AMARK,
    S_FRD, S_FCHK0, S_FCLR, S_FCHK, S_RESP
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   clr_q;
  logic [15:0]     cs_q, ce_q, hs_q;
  logic            fit_q;
  logic [RW-1:0]   rover_q;
  logic [1:0]      kind_q;
  logic [31:0]     addr_q, wd_q, acc_q;
  logic [12:0]     n_q;
  logic [KW-1:0]   k_q;
  logic [OW-1:0]   off_q, first_q;
  logic            phase2_q;
  logic [31:0]     pend_val_q;
  logic [1:0]      pend_st_q;
  logic            out_valid_q;
  logic [31:0]     res_q;
  logic [1:0]      stat_q;

  logic          d_we, m_we;
  logic [AW-1:0] d_waddr, d_raddr;
  logic [7:0]    d_wdata, d_rdata;
  logic [HW-1:0] m_waddr, m_raddr;
  logic [1:0]    m_wdata, m_rdata;

  logic [32:0]   acc_end, dfull;
  logic [31:0]   a_diff;
  logic          a_in_heap;
  logic [OW-1:0] a_off, off_k, off_k1, skip_off, first_c, limit;
  logic [RW-1:0] r_diff, blk;
  logic          r_in;
  logic [13:0]   n_round;
  logic [KW-1:0] k_next;
  logic          k_last, w_ok, too_big;

  always_comb begin
    acc_end   = {1'b0, addr_q} + 33'(n_q);
    dfull     = {1'b0, addr_q} + 33'(k_q);
    a_diff    = addr_q - {16'd0, hs_q};
    a_in_heap = (addr_q >= {16'd0, hs_q}) && (a_diff < 32'(HEAP_BYTES));
    a_off     = a_diff[OW-1:0];
    off_k     = off_q + k_q[OW-1:0];
    off_k1    = off_k + OW'(1);
    skip_off  = (off_k & ~OW'(3)) + OW'(4);
    r_diff    = rover_q - RW'(hs_q);
    r_in      = (rover_q >= RW'(hs_q)) && (r_diff < RW'(HEAP_BYTES));
    first_c   = (fit_q && r_in) ? (r_diff[OW-1:0] & ~OW'(3)) : '0;
    limit     = phase2_q ? first_q : OW'(HEAP_BYTES);
    too_big   = (32'(n_q) + 32'(off_q)) > 32'(HEAP_BYTES);
    blk       = RW'(hs_q) + RW'(off_q);
    n_round   = ({1'b0, n_q} + 14'd3) & ~14'd3;
    k_next    = k_q + KW'(1);
    k_last    = (k_next == KW'(n_q));
    w_ok      = (n_q == 13'd1) || (n_q == 13'd2) || (n_q == 13'd4);
  end

  // memory port steering
  always_comb begin
    d_we    = 1'b0;
    d_waddr = dfull[AW-1:0];
    d_wdata = 8'((wd_q >> {k_q[1:0], 3'b000}) & 32'h0000_00ff);
    d_raddr = dfull[AW-1:0];
    m_we    = 1'b0;
    m_waddr = off_k[HW-1:0];
    m_wdata = hac_pkg::MapFree;
    m_raddr = off_k[HW-1:0];
    case (state_q)
      S_CLR: begin
        d_we    = 32'(clr_q) < 32'(MEM_BYTES);
        d_waddr = AW'(clr_q);
        d_wdata = 8'd0;
        m_we    = 32'(clr_q) < 32'(HEAP_BYTES);
        m_waddr = HW'(clr_q);
      end
      S_DWR: d_we = 1'b1;
      S_AMARK: begin
        m_we    = 1'b1;
        m_wdata = (k_q == '0) ? hac_pkg::MapHead : hac_pkg::MapCont;
      end
      S_FRD: m_raddr = a_off[HW-1:0];
      S_FCLR: begin
        m_we    = 1'b1;
        d_we    = dfull < 33'(MEM_BYTES);
        d_wdata = 8'd0;
        m_raddr = off_k1[HW-1:0];
      end
      default: ;
    endcase
  end

  hac_ram #(.Width(8), .Depth(MEM_BYTES)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  hac_ram #(.Width(2), .Depth(HEAP_BYTES)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      cs_q        <= hac_pkg::CodeStartRst;
      ce_q        <= hac_pkg::CodeEndRst;
      hs_q        <= hac_pkg::HeapStartRst;
      fit_q       <= 1'b0;
      rover_q     <= RW'(hac_pkg::HeapStartRst);
      kind_q      <= hac_pkg::KindLoad;
      addr_q      <= '0;
      wd_q        <= '0;
      acc_q       <= '0;
      n_q         <= '0;
      k_q         <= '0;
      off_q       <= '0;
      first_q     <= '0;
      phase2_q    <= 1'b0;
      pend_val_q  <= '0;
      pend_st_q   <= hac_pkg::StOk;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      stat_q      <= hac_pkg::StOk;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          hac_pkg::CfgCodeStart: cs_q  <= cfg_data_i;
          hac_pkg::CfgCodeEnd:   ce_q  <= cfg_data_i;
          hac_pkg::CfgHeapStart: hs_q  <= cfg_data_i;
          hac_pkg::CfgFitMode:   fit_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      // the response state refills the register itself
      if (out_valid_q && !out_stall_i && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + CW'(1);
          if (clr_q == CW'(ClrN - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q     <= kind_i;
            addr_q     <= address_i;
            n_q        <= byte_count_i;
            wd_q       <= write_data_i;
            acc_q      <= '0;
            k_q        <= '0;
            pend_val_q <= '0;
            pend_st_q  <= hac_pkg::StOk;
            case (kind_i)
              hac_pkg::KindAlloc: state_q <= S_AINIT;
              hac_pkg::KindFree:  state_q <= S_FRD;
              default:            state_q <= S_CHK;
            endcase
          end
        end
        S_CHK: begin
          if (!w_ok || acc_end > 33'(MEM_BYTES) || addr_q < {16'd0, cs_q} ||
              (kind_q == hac_pkg::KindStore && addr_q < {16'd0, ce_q})) begin
            pend_st_q <= hac_pkg::StDenied;
            state_q   <= S_RESP;
          end else if (a_in_heap) begin
            off_q   <= a_off;
            state_q <= S_MRD;
          end else if (n_q == 13'd4 && addr_q[1:0] != 2'd0) begin
            pend_st_q <= hac_pkg::StDenied;
            state_q   <= S_RESP;
          end else begin
            state_q <= (kind_q == hac_pkg::KindStore) ? S_DWR : S_DRD;
          end
        end
        S_MRD: begin
          if (k_q != '0 && 32'(off_k) >= 32'(HEAP_BYTES)) begin
            pend_st_q <= hac_pkg::StDenied;
            state_q   <= S_RESP;
          end else begin
            state_q <= S_MCHK;
          end
        end
        S_MCHK: begin
          if ((k_q == '0 && m_rdata == hac_pkg::MapFree) ||
              (k_q != '0 && m_rdata != hac_pkg::MapCont)) begin
            pend_st_q <= hac_pkg::StDenied;
            state_q   <= S_RESP;
          end else if (k_last) begin
            k_q     <= '0;
            state_q <= (kind_q == hac_pkg::KindStore) ? S_DWR : S_DRD;
          end else begin
            k_q     <= k_next;
            state_q <= S_MRD;
          end
        end
        S_DRD: state_q <= S_DCHK;
        S_DCHK: begin
          acc_q <= acc_q | ({24'd0, d_rdata} << {k_q[1:0], 3'b000});
          if (k_last) begin
            pend_val_q <= acc_q | ({24'd0, d_rdata} << {k_q[1:0], 3'b000});
            state_q    <= S_RESP;
          end else begin
            k_q     <= k_next;
            state_q <= S_DRD;
          end
        end
        S_DWR: begin
          k_q <= k_next;
          if (k_last) begin
            state_q <= S_RESP;
          end
        end
        S_AINIT: begin
          if (n_q == 13'd0 || 32'(n_q) > 32'(HEAP_BYTES)) begin
            pend_st_q <= hac_pkg::StNoSpace;
            state_q   <= S_RESP;
          end else begin
            off_q    <= first_c;
            first_q  <= first_c;
            phase2_q <= 1'b0;
            state_q  <= S_ACAND;
          end
        end
        S_ACAND: begin
          k_q <= '0;
          if (off_q >= limit || too_big) begin
            if (!phase2_q) begin
              phase2_q <= 1'b1;
              off_q    <= '0;
            end else begin
              pend_st_q <= hac_pkg::StNoSpace;
              state_q   <= S_RESP;
            end
          end else begin
            state_q <= S_ARD;
          end
        end
        S_ARD: state_q <= S_ACHK;
        S_ACHK: begin
          if (m_rdata != hac_pkg::MapFree) begin
            // no aligned start up to the taken byte can hold the run
            off_q   <= skip_off;
            state_q <= S_ACAND;
          end else if (k_last) begin
            k_q     <= '0;
            state_q <= S_AMARK;
          end else begin
            k_q     <= k_next;
            state_q <= S_ARD;
          end
        end
        S_AMARK: begin
          k_q <= k_next;
          if (k_last) begin
            pend_val_q <= 32'(blk);
            if (fit_q) begin
              rover_q <= blk + RW'(n_round);
            end
            state_q <= S_RESP;
          end
        end
        S_FRD: begin
          if (!a_in_heap) begin
            pend_st_q <= hac_pkg::StBadFree;
            state_q   <= S_RESP;
          end else begin
            off_q   <= a_off;
            state_q <= S_FCHK0;
          end
        end
        S_FCHK0: begin
          if (m_rdata != hac_pkg::MapHead) begin
            pend_st_q <= hac_pkg::StBadFree;
            state_q   <= S_RESP;
          end else begin
            rover_q <= RW'(addr_q);
            state_q <= S_FCLR;
          end
        end
        S_FCLR: begin
          k_q <= k_next;
          if (32'(off_k1) >= 32'(HEAP_BYTES)) begin
            state_q <= S_RESP;
          end else begin
            state_q <= S_FCHK;
          end
        end
        S_FCHK: begin
          state_q <= (m_rdata == hac_pkg::MapCont) ? S_FCLR : S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            res_q       <= pend_val_q;
            stat_q      <= pend_st_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign status_o       = stat_q;

  `HAC_ASSERT_SAME(a_err_zero, out_valid_o && status_o != hac_pkg::StOk, result_value_o == 32'd0)
  `HAC_ASSERT_NEXT(a_busy_after_beat, in_valid_i && !in_stall_o, in_stall_o)
  `HAC_ASSERT_SAME(a_resp_origin, $rose(out_valid_o), $past(state_q == S_RESP))
endmodule
`default_nettype wire
